### rtl/rsl_pkg.sv
`default_nettype none

package rsl_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // opcodes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch endpoints, start the run divide
    logic finish;  // take quotient and remainder, line becomes drawable
    logic step;    // emit one pixel and advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;  // quotient and remainder are ready
    logic last;      // current pixel is the final one of the line
  } status_t;

endpackage

`default_nettype wire

### rtl/rsl_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rsl_div #(
  parameter int W = rsl_pkg::COORD_BITS_DEF + 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CNTW = $clog2(W);
  localparam logic [CNTW-1:0] LAST = CNTW'(W - 1);

  logic            busy;
  logic [CNTW-1:0] count;
  logic [W-1:0]    dvs;
  logic [W:0]      rem_sh;
  logic            fits;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {remainder, quotient[W-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == LAST);
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quotient register doubles as the dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= W'(rem_sh - {1'b0, dvs});
      end else begin
        remainder <= rem_sh[W-1:0];
      end
      quotient <= {quotient[W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/rsl_datapath.sv
`default_nettype none

module rsl_datapath #(
  parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rsl_pkg::cmd_t         cmd,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       last_pixel,
  output rsl_pkg::status_t           status
);

  localparam int CW = COORD_BITS + 1;

  // line state
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic                  y_step_down;
  logic                  x_is_major;
  logic [CW-1:0]         run_base;
  logic [CW-1:0]         run_extra;
  logic [CW-1:0]         run_divisor;
  logic [CW-1:0]         wrap_accum;
  logic [CW-1:0]         run_left;
  logic [CW-1:0]         pixels_left;

  // load-time geometry
  logic                  swap;
  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [COORD_BITS-1:0] dx, ady, dmin, dmax;
  logic                  dy_pos;
  logic [CW-1:0]         dmin_p1, dmax_p1;

  // divider hookup
  logic          div_done;
  logic [CW-1:0] div_quo;
  logic [CW-1:0] div_rem;

  // step-time next values
  logic [COORD_BITS-1:0] x_inc, y_inc;
  logic [CW-1:0]         run_dec;
  logic                  run_end;
  logic [CW:0]           acc_sum;
  logic [CW-1:0]         acc_new;
  logic                  bump;

  // order endpoints so x rises, find extents
  always_comb begin
    swap    = !(start_x < end_x);
    x1      = swap ? end_x   : start_x;
    y1      = swap ? end_y   : start_y;
    x2      = swap ? start_x : end_x;
    y2      = swap ? start_y : end_y;
    dx      = x2 - x1;
    dy_pos  = y2 > y1;
    ady     = dy_pos ? (y2 - y1) : (y1 - y2);
    dmin    = (dx < ady) ? dx  : ady;
    dmax    = (dx < ady) ? ady : dx;
    dmin_p1 = {1'b0, dmin} + 1'b1;
    dmax_p1 = {1'b0, dmax} + 1'b1;
  end

  rsl_div #(
    .W (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .dividend  (dmax_p1),
    .divisor   (dmin_p1),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // per-pixel advance: major step always, minor step at run end
  always_comb begin
    x_inc   = cur_x + 1'b1;
    y_inc   = y_step_down ? (cur_y - 1'b1) : (cur_y + 1'b1);
    run_dec = run_left - 1'b1;
    run_end = (run_dec == '0);
    acc_sum = {1'b0, wrap_accum} + {1'b0, run_extra};
    if (acc_sum >= {1'b0, run_divisor}) begin
      acc_new = CW'(acc_sum - {1'b0, run_divisor});
    end else begin
      acc_new = acc_sum[CW-1:0];
    end
    bump = ({1'b0, acc_new} + {1'b0, run_extra}) >= {1'b0, run_divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x       <= x1;
      cur_y       <= y1;
      y_step_down <= !dy_pos;
      x_is_major  <= dx > ady;
      run_divisor <= dmin_p1;
      pixels_left <= dmax_p1;
    end else if (cmd.finish) begin
      run_base   <= div_quo;
      run_extra  <= div_rem;
      run_left   <= div_quo;
      wrap_accum <= '0;
    end else if (cmd.step) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      last_pixel  <= (pixels_left == CW'(1));
      pixels_left <= pixels_left - 1'b1;
      if (x_is_major || run_end) begin
        cur_x <= x_inc;
      end
      if (!x_is_major || run_end) begin
        cur_y <= y_inc;
      end
      if (run_end) begin
        wrap_accum <= acc_new;
        run_left   <= run_base + CW'(bump);
      end else begin
        run_left <= run_dec;
      end
    end
  end

  assign status.div_done = div_done;
  assign status.last     = (pixels_left == CW'(1));

endmodule

`default_nettype wire

### rtl/rsl_ctrl.sv
`default_nettype none

module rsl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             opcode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire rsl_pkg::status_t status,
  output rsl_pkg::cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // no line
  localparam logic [1:0] ST_DIV  = 2'd1;  // sizing runs
  localparam logic [1:0] ST_LINE = 2'd2;  // line active

  logic [1:0] state, state_next;
  logic       out_valid_next;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    in_ready       = (state inside {ST_IDLE, ST_LINE}) && (!out_valid || out_ready);
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE, ST_LINE: begin
        if (in_valid && in_ready) begin
          if (opcode == rsl_pkg::OP_LOAD) begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end else if (state == ST_LINE) begin
            // step: one pixel word
            cmd.step       = 1'b1;
            out_valid_next = 1'b1;
            if (status.last) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.finish = 1'b1;
          state_next = ST_LINE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/run_slice_line_rasterizer_top.sv
`default_nettype none

// Channel  Handshake             Word
// input    in_valid / in_ready   opcode, start_x, start_y, end_x, end_y
// output   out_valid / out_ready pixel_x, pixel_y, last_pixel
//
// A step word gives one pixel word; steps stream back to back while the output
// register drains.
// A load word holds off the next word until the one-bit-per-cycle run-length
// divider (COORD_BITS + 1 iterations) is done.
// A step with no line loaded is taken and gives no word.
// Input is held off while a pixel word waits and out_ready is low.
// rst is synchronous; after it no line is loaded.
module run_slice_line_rasterizer_top #(
  parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       last_pixel
);

  rsl_pkg::cmd_t    cmd;
  rsl_pkg::status_t status;

  rsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsl_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel),
    .status     (status)
  );

endmodule

`default_nettype wire
